// ----- hw/rtl/mch_pkg.sv -----
// Package for the magnetometer compass heading core: payload types, gain table,
// arctangent table and register indexes. No dependencies.
package mch_pkg;

  localparam int unsigned CordicStagesDefault = 16;
  localparam int unsigned AtanTableSize = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CordicW = 34;
  localparam int unsigned AngleW = 28;

  localparam logic [CfgIdxW-1:0] RegGainCode = 3'd0;
  localparam logic [CfgIdxW-1:0] RegXCorr = 3'd1;
  localparam logic [CfgIdxW-1:0] RegYCorr = 3'd2;
  localparam logic [CfgIdxW-1:0] RegZCorr = 3'd3;
  localparam logic [CfgIdxW-1:0] RegXOff = 3'd4;
  localparam logic [CfgIdxW-1:0] RegYOff = 3'd5;
  localparam logic [CfgIdxW-1:0] RegZOff = 3'd6;

  typedef struct packed {
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
  } sample_t;

  typedef struct packed {
    logic signed [19:0] scaled_x;
    logic signed [19:0] scaled_y;
    logic signed [19:0] scaled_z;
    logic [14:0] bearing;
  } result_t;

  function automatic logic [14:0] gain_q12(input logic [2:0] code);
    logic [14:0] g;
    case (code)
      3'd0: g = 15'd2990;
      3'd1: g = 15'd3768;
      3'd2: g = 15'd4997;
      3'd3: g = 15'd6226;
      3'd4: g = 15'd9298;
      3'd5: g = 15'd10486;
      3'd6: g = 15'd12411;
      default: g = 15'd17818;
    endcase
    return g;
  endfunction

  function automatic logic [AngleW-1:0] atan_entry(input int unsigned i);
    logic [AngleW-1:0] a;
    case (i)
      0: a = 28'd2949120;
      1: a = 28'd1740967;
      2: a = 28'd919879;
      3: a = 28'd466945;
      4: a = 28'd234379;
      5: a = 28'd117304;
      6: a = 28'd58666;
      7: a = 28'd29335;
      8: a = 28'd14668;
      9: a = 28'd7334;
      10: a = 28'd3667;
      11: a = 28'd1833;
      12: a = 28'd917;
      13: a = 28'd458;
      14: a = 28'd229;
      15: a = 28'd115;
      16: a = 28'd57;
      17: a = 28'd29;
      18: a = 28'd14;
      19: a = 28'd7;
      20: a = 28'd4;
      21: a = 28'd2;
      22: a = 28'd1;
      default: a = 28'd0;
    endcase
    return a;
  endfunction

endpackage

// ----- hw/rtl/mch_scale.sv -----
// Three-stage axis scaler: raw * gain, then * correction, then round, offset, saturate.
// No dependencies.
module mch_scale (
  input  logic               clk_i,
  input  logic signed [15:0] raw_i,
  input  logic [14:0]        gain_i,
  input  logic [15:0]        corr_i,
  input  logic signed [13:0] off_i,
  output logic signed [19:0] scaled_o
);

  logic signed [31:0] prod1_q, prod1_d;
  logic signed [48:0] prod2_q, prod2_d;
  logic signed [50:0] sum_w;
  logic signed [24:0] rnd_w;
  logic signed [19:0] scaled_q, scaled_d;

  assign prod1_d = raw_i * $signed({1'b0, gain_i});
  assign prod2_d = prod1_q * $signed({1'b0, corr_i});

  always_comb begin
    sum_w = 51'(prod2_q) + 51'(33554432);
    rnd_w = 25'(sum_w >>> 26) + 25'(off_i);
    if (rnd_w > 25'sd524287) begin
      scaled_d = 20'sd524287;
    end else if (rnd_w < -25'sd524288) begin
      scaled_d = -20'sd524288;
    end else begin
      scaled_d = rnd_w[19:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod1_q  <= prod1_d;
    prod2_q  <= prod2_d;
    scaled_q <= scaled_d;
  end

  assign scaled_o = scaled_q;

endmodule

// ----- hw/rtl/magnetometer_compass_heading_core.sv -----
// Magnetometer compass heading core: scaling pipeline and unrolled CORDIC bearing.
// CORDIC_STAGES above 24 count as 24.
// One sample per cycle; each CORDIC iteration and each multiply owns one register stage.
// Reset clears valid bits and loads register reset values; done_o cannot be stalled.
// Depends on mch_pkg and mch_scale.
module magnetometer_compass_heading_core #(
  parameter int unsigned CORDIC_STAGES = mch_pkg::CordicStagesDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  mch_pkg::sample_t            sample_i,
  output logic                        done_o,
  output mch_pkg::result_t            result_o,
  input  logic                        cfg_we_i,
  input  logic [mch_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mch_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned N = (CORDIC_STAGES > mch_pkg::AtanTableSize) ?
                              mch_pkg::AtanTableSize : CORDIC_STAGES;
  localparam int unsigned W = mch_pkg::CordicW;
  localparam int unsigned AW = mch_pkg::AngleW;

  logic [2:0] gain_code_q;
  logic [15:0] xcorr_q, ycorr_q, zcorr_q;
  logic signed [13:0] xoff_q, yoff_q, zoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_code_q <= '0;
      xcorr_q <= 16'd16384;
      ycorr_q <= 16'd16384;
      zcorr_q <= 16'd16384;
      xoff_q <= '0;
      yoff_q <= '0;
      zoff_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mch_pkg::RegGainCode: gain_code_q <= cfg_data_i[2:0];
        mch_pkg::RegXCorr: xcorr_q <= cfg_data_i;
        mch_pkg::RegYCorr: ycorr_q <= cfg_data_i;
        mch_pkg::RegZCorr: zcorr_q <= cfg_data_i;
        mch_pkg::RegXOff: xoff_q <= cfg_data_i[13:0];
        mch_pkg::RegYOff: yoff_q <= cfg_data_i[13:0];
        mch_pkg::RegZOff: zoff_q <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [14:0] gain_w;
  assign gain_w = mch_pkg::gain_q12(gain_code_q);

  logic signed [19:0] sx_w, sy_w, sz_w;

  mch_scale u_scale_x (.clk_i, .raw_i(sample_i.raw_x), .gain_i(gain_w), .corr_i(xcorr_q),
                       .off_i(xoff_q), .scaled_o(sx_w));
  mch_scale u_scale_y (.clk_i, .raw_i(sample_i.raw_y), .gain_i(gain_w), .corr_i(ycorr_q),
                       .off_i(yoff_q), .scaled_o(sy_w));
  mch_scale u_scale_z (.clk_i, .raw_i(sample_i.raw_z), .gain_i(gain_w), .corr_i(zcorr_q),
                       .off_i(zoff_q), .scaled_o(sz_w));

  logic [2:0] vin_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vin_q <= '0;
    end else begin
      vin_q <= {vin_q[1:0], start};
    end
  end

  logic              v_q [N+1];
  logic signed [W-1:0] cx_q [N+1];
  logic signed [W-1:0] cy_q [N+1];
  logic signed [AW-1:0] cz_q [N+1];
  logic signed [19:0] px_q [N+1];
  logic signed [19:0] py_q [N+1];
  logic signed [19:0] pz_q [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= vin_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    px_q[0] <= sx_w;
    py_q[0] <= sy_w;
    pz_q[0] <= sz_w;
    cz_q[0] <= '0;
    if (sy_w[19]) begin
      cx_q[0] <= -(W'(sy_w) <<< 10);
      cy_q[0] <= -(W'(sx_w) <<< 10);
    end else begin
      cx_q[0] <= W'(sy_w) <<< 10;
      cy_q[0] <= W'(sx_w) <<< 10;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    logic signed [AW-1:0] at_w;
    assign at_w = mch_pkg::atan_entry(i);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      px_q[i+1] <= px_q[i];
      py_q[i+1] <= py_q[i];
      pz_q[i+1] <= pz_q[i];
      if (!cy_q[i][W-1]) begin
        cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
        cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
        cz_q[i+1] <= cz_q[i] + at_w;
      end else begin
        cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
        cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
        cz_q[i+1] <= cz_q[i] - at_w;
      end
    end
  end

  logic signed [AW-1:0] zsum_w;
  logic signed [17:0] zr_w, zc_w;
  logic signed [17:0] b_w;
  logic done_q;
  mch_pkg::result_t res_q, res_d;

  always_comb begin
    zsum_w = cz_q[N] + AW'(512);
    zr_w = 18'(zsum_w >>> 10);
    if (zr_w > 18'sd5760) begin
      zc_w = 18'sd5760;
    end else if (zr_w < -18'sd5760) begin
      zc_w = -18'sd5760;
    end else begin
      zc_w = zr_w;
    end
    b_w = (py_q[N][19] ? 18'sd17280 : 18'sd5760) - zc_w;
    if (b_w >= 18'sd23040) begin
      b_w = b_w - 18'sd23040;
    end
    if (py_q[N] == '0) begin
      b_w = px_q[N][19] ? 18'sd11520 : 18'sd0;
    end
    res_d.scaled_x = px_q[N];
    res_d.scaled_y = py_q[N];
    res_d.scaled_z = pz_q[N];
    res_d.bearing  = b_w[14:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign result_o = res_q;

endmodule

// ----- tb/heading_checker.sv -----
// Checker for the magnetometer compass heading core: tracks register writes, predicts each
// sample's scaled fields and bearing, and compares them with the results. Depends on mch_pkg.
module heading_checker #(
  parameter int unsigned CORDIC_STAGES = mch_pkg::CordicStagesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  mch_pkg::sample_t             sample_i,
  input  logic                         done_i,
  input  mch_pkg::result_t             result_i,
  input  logic                         cfg_we_i,
  input  logic [mch_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mch_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           errors_o,
  output int                           outstanding_o,
  output int                           checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mch_pkg::*;

  localparam longint GainTab [8] = '{2990, 3768, 4997, 6226, 9298, 10486, 12411, 17818};
  localparam longint ArcTab [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  logic [2:0] gain_sel;
  longint     corr [3];
  longint     offs [3];
  result_t    heading_q[$];
  int         errors;
  int         checked;

  function automatic longint scale_axis(longint raw, longint cr, longint off);
    longint p;
    longint v;
    p = raw * GainTab[gain_sel] * cr;
    v = ((p + (64'sd1 <<< 25)) >>> 26) + off;
    if (v > 524287) v = 524287;
    if (v < -524288) v = -524288;
    return v;
  endfunction

  function automatic result_t predict_heading(sample_t s);
    result_t r;
    longint sx, sy, sz, xx, yy, dx, dy, z, zr, b;
    int     n;
    sx = scale_axis(longint'(s.raw_x), corr[0], offs[0]);
    sy = scale_axis(longint'(s.raw_y), corr[1], offs[1]);
    sz = scale_axis(longint'(s.raw_z), corr[2], offs[2]);
    if (sy == 0) begin
      b = (sx < 0) ? 11520 : 0;
    end else begin
      xx = ((sy > 0) ? sy : -sy) * 1024;
      yy = ((sy > 0) ? sx : -sx) * 1024;
      z = 0;
      n = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
      for (int i = 0; i < n; i++) begin
        dx = yy >>> i;
        dy = xx >>> i;
        if (yy >= 0) begin
          xx += dx;
          yy -= dy;
          z += ArcTab[i];
        end else begin
          xx -= dx;
          yy += dy;
          z -= ArcTab[i];
        end
      end
      zr = (z + 512) >>> 10;
      if (zr > 5760) zr = 5760;
      if (zr < -5760) zr = -5760;
      b = ((sy > 0) ? 5760 : 17280) - zr;
      if (b >= 23040) b -= 23040;
    end
    r.scaled_x = sx[19:0];
    r.scaled_y = sy[19:0];
    r.scaled_z = sz[19:0];
    r.bearing  = b[14:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      gain_sel = 3'd0;
      corr = '{16384, 16384, 16384};
      offs = '{0, 0, 0};
      heading_q.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegGainCode: gain_sel = cfg_data_i[2:0];
          RegXCorr: corr[0] = longint'(cfg_data_i);
          RegYCorr: corr[1] = longint'(cfg_data_i);
          RegZCorr: corr[2] = longint'(cfg_data_i);
          RegXOff: offs[0] = longint'($signed(cfg_data_i[13:0]));
          RegYOff: offs[1] = longint'($signed(cfg_data_i[13:0]));
          RegZOff: offs[2] = longint'($signed(cfg_data_i[13:0]));
          default: ;
        endcase
      end
      if (done_i) begin
        if (heading_q.size() == 0) begin
          $display("%0t: result with no sample pending, actual %h", $time, result_i);
          errors++;
        end else begin
          e = heading_q.pop_front();
          checked++;
          if (result_i.scaled_x !== e.scaled_x) begin
            $display("%0t: scaled_x expected %0d actual %0d", $time, e.scaled_x,
                     result_i.scaled_x);
            errors++;
          end
          if (result_i.scaled_y !== e.scaled_y) begin
            $display("%0t: scaled_y expected %0d actual %0d", $time, e.scaled_y,
                     result_i.scaled_y);
            errors++;
          end
          if (result_i.scaled_z !== e.scaled_z) begin
            $display("%0t: scaled_z expected %0d actual %0d", $time, e.scaled_z,
                     result_i.scaled_z);
            errors++;
          end
          if (result_i.bearing !== e.bearing) begin
            $display("%0t: bearing expected %0d actual %0d", $time, e.bearing,
                     result_i.bearing);
            errors++;
          end
        end
      end
      if (start_i && !busy_i) heading_q.push_back(predict_heading(sample_i));
    end
    errors_o = errors;
    outstanding_o = heading_q.size();
    checked_o = checked;
  end

endmodule

// ----- tb/magnetometer_compass_heading_core_tb.sv -----
// Top of the compass heading testbench: clock, reset, register settings and sample stimulus.
// Depends on mch_pkg, magnetometer_compass_heading_core and heading_checker.
module magnetometer_compass_heading_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mch_pkg::*;

  localparam int unsigned Latency = CordicStagesDefault + 6;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  sample_t             sample_i = '0;
  logic                done_o;
  result_t             result_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = RegGainCode;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int                  errors;
  int                  outstanding;
  int                  checked;
  int                  sent = 0;
  int                  settings = 0;

  magnetometer_compass_heading_core uut (
    .clk_i, .rst_ni, .start, .busy, .sample_i, .done_o, .result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  heading_checker chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .sample_i, .done_i(done_o),
    .result_i(result_o), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .outstanding_o(outstanding), .checked_o(checked)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still pending.", outstanding);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_sample(input sample_t s, input int idle_pct);
    start <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (busy);
    sent++;
    @(negedge clk_i);
    while (int'($urandom_range(99)) < idle_pct) begin
      start <= 1'b0;
      sample_i <= sample_t'({$urandom, 16'($urandom)});
      @(negedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic apply_setting(input logic [2:0] g, input logic [15:0] cx, input logic [15:0] cy,
                               input logic [15:0] cz, input logic [13:0] ox,
                               input logic [13:0] oy, input logic [13:0] oz);
    logic [CfgIdxW-1:0]  idx [7];
    logic [CfgDataW-1:0] val [7];
    idx = '{RegGainCode, RegXCorr, RegYCorr, RegZCorr, RegXOff, RegYOff, RegZOff};
    val = '{{13'd0, g}, cx, cy, cz, {2'b00, ox}, {2'b00, oy}, {2'b00, oz}};
    drain();
    for (int i = 0; i < 7; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= val[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  function automatic sample_t random_sample();
    sample_t s;
    s = sample_t'({$urandom, 16'($urandom)});
    case ($urandom_range(9))
      0: s.raw_y = '0;
      1: begin
        s.raw_x = 16'($signed($urandom_range(128)) - 64);
        s.raw_y = 16'($signed($urandom_range(128)) - 64);
      end
      2: s.raw_x = '0;
      default: ;
    endcase
    return s;
  endfunction

  initial begin
    sample_t directed [$];
    int      idle_pct;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    apply_setting(3'd0, 16'd16384, 16'd16384, 16'd16384, 14'd0, 14'd0, 14'd0);
    directed = '{
      '{16'sd0, 16'sd0, 16'sd0},
      '{16'sd32767, 16'sd32767, 16'sd32767},
      '{-16'sd32768, -16'sd32768, -16'sd32768},
      '{-16'sd500, 16'sd0, 16'sd7},
      '{16'sd500, 16'sd0, -16'sd7},
      '{16'sd32767, -16'sd1, 16'sd0},
      '{-16'sd32768, 16'sd1, 16'sd1},
      '{16'sd0, 16'sd1000, 16'sd0},
      '{16'sd0, -16'sd1000, 16'sd0},
      '{16'sd1000, 16'sd1000, -16'sd1},
      '{-16'sd1000, -16'sd1000, 16'sd1},
      '{16'sd1, 16'sd1, 16'sd1}};
    foreach (directed[i]) send_sample(directed[i], 0);

    apply_setting(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 14'h1FFF, 14'h1FFF, 14'h1FFF);
    directed = '{
      '{16'sd32767, 16'sd32767, 16'sd32767},
      '{-16'sd32768, -16'sd32768, -16'sd32768},
      '{16'sd0, -16'sd1, 16'sd0},
      '{-16'sd20000, 16'sd12345, 16'sd3}};
    foreach (directed[i]) send_sample(directed[i], 0);

    apply_setting(3'd4, 16'd0, 16'd0, 16'd0, 14'h2000, 14'h2000, 14'h2000);
    directed = '{
      '{16'sd32767, -16'sd32768, 16'sd1},
      '{-16'sd1, 16'sd1, -16'sd32768}};
    foreach (directed[i]) send_sample(directed[i], 0);

    for (int set_no = 0; set_no < 8; set_no++) begin
      if (set_no == 0)
        apply_setting(3'd0, 16'd16384, 16'd16384, 16'd16384, 14'd0, 14'd0, 14'd0);
      else if (set_no == 1)
        apply_setting(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 14'h2000, 14'h1FFF, 14'h2000);
      else
        apply_setting(3'($urandom_range(7)), 16'($urandom), 16'($urandom), 16'($urandom),
                      14'($urandom), 14'($urandom), 14'($urandom));
      for (int k = 0; k < 250; k++) begin
        case ((set_no + k / 60) % 4)
          1: idle_pct = 71;
          3: idle_pct = 6;
          default: idle_pct = 0;
        endcase
        if (k == 125) drain();
        send_sample(random_sample(), idle_pct);
      end
    end

    start <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
    $display("Sent %0d samples and checked %0d results under %0d register settings,",
             sent, checked, settings);
    $display("with gain and offset extremes, zero y, saturation and idle gaps.");
    if (errors == 0 && checked == sent) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
